[sv/tfd_pkg.sv]
// ----------------------------------------------------------------------------
// tfd_pkg
// shared constants and types for the trainer frame decoder
// ----------------------------------------------------------------------------
package tfd_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 32;
    localparam int NUM_CHANNELS        = 8;
    localparam int CHAN_W              = 12;

    localparam int STORE_DEPTH = 14;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int MIN_LEN     = 14;
    localparam int CHK_POS     = 13;

    localparam logic [7:0] DELIM      = 8'h7E;
    localparam logic [7:0] ESC        = 8'h7D;
    localparam logic [7:0] ESC_MASK   = 8'h20;
    localparam logic [7:0] FRAME_TYPE = 8'h80;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_START  = 4'b0010,
        ST_FRAME  = 4'b0100,
        ST_ESCAPE = 4'b1000
    } dfr_state_t;

    typedef logic [STORE_DEPTH-1:0][7:0]       store_t;
    typedef logic [NUM_CHANNELS-1:0][CHAN_W-1:0] chan_arr_t;

    typedef struct packed {
        logic emit;      // accepted delimiter closes a frame that passes
        logic in_frame;  // deframer sits in the in-frame state
    } dfr_status_t;

endpackage

[sv/tfd_deframer.sv]
// ----------------------------------------------------------------------------
// tfd_deframer
// delimiter/escape state machine, byte store, running xor and frame check
// ----------------------------------------------------------------------------
module tfd_deframer #(
    parameter int MAX_FRAME_BYTES = tfd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_accept,
    input  logic [7:0]           byte_in,
    output tfd_pkg::store_t      store,
    output tfd_pkg::dfr_status_t status
);
    import tfd_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

    dfr_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       xor_reg, xor_next;
    store_t           store_reg;

    logic       do_store;
    logic [7:0] store_data;
    logic       frame_pass;

    // store only bytes inside the first STORE_DEPTH positions
    always_comb begin
        do_store   = 1'b0;
        store_data = byte_in;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (byte_in == DELIM) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (byte_in == DELIM) begin
                    state_next = ST_FRAME;
                end else begin
                    do_store = 1'b1;
                end
            end
            ST_FRAME: begin
                if (byte_in == ESC) begin
                    state_next = ST_ESCAPE;
                end else if (byte_in != DELIM) begin
                    do_store = 1'b1;
                end
            end
            ST_ESCAPE: begin
                do_store   = 1'b1;
                store_data = byte_in ^ ESC_MASK;
                state_next = ST_FRAME;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        xor_next   = xor_reg;
        if (do_store) begin
            if (count_reg < CNT_W'(MAX_FRAME_BYTES)) begin
                count_next = count_reg + CNT_W'(1);
                if (count_reg < CNT_W'(CHK_POS)) begin
                    xor_next = xor_reg ^ store_data;
                end
            end
        end else if (byte_in == DELIM) begin
            count_next = '0;
            xor_next   = '0;
        end
    end

    assign frame_pass = (count_reg >= CNT_W'(MIN_LEN))
                     && (xor_reg == store_reg[CHK_POS])
                     && (store_reg[0] == FRAME_TYPE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            xor_reg   <= '0;
        end else if (byte_accept) begin
            state_reg <= state_next;
            count_reg <= count_next;
            xor_reg   <= xor_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_accept && do_store && (count_reg < CNT_W'(STORE_DEPTH))) begin
            store_reg[count_reg[IDX_W-1:0]] <= store_data;
        end
    end

    assign store           = store_reg;
    assign status.in_frame = (state_reg == ST_FRAME);
    assign status.emit     = byte_accept && (state_reg == ST_FRAME)
                          && (byte_in == DELIM) && frame_pass;

endmodule

[sv/tfd_unpack.sv]
// ----------------------------------------------------------------------------
// tfd_unpack
// splits stored payload bytes into 12-bit channels, three bytes per pair
// ----------------------------------------------------------------------------
module tfd_unpack (
    input  tfd_pkg::store_t    store,
    output tfd_pkg::chan_arr_t chans
);
    import tfd_pkg::*;

    always_comb begin
        for (int p = 0; p < NUM_CHANNELS / 2; p++) begin
            // b1 = store[1+3p], b2 = store[2+3p], b3 = store[3+3p]
            chans[2*p]   = {store[2+3*p][7:4], store[1+3*p]};
            chans[2*p+1] = {store[3+3*p][3:0], store[2+3*p][3:0], store[3+3*p][7:4]};
        end
    end

endmodule

[sv/trainer_frame_decoder_core.sv]
// ----------------------------------------------------------------------------
// trainer_frame_decoder_core
// byte-stuffed trainer frame deframer with eight-channel unpacker
// ----------------------------------------------------------------------------
// Takes one received serial byte per beat and emits one beat of eight 12-bit
// channel values for every good frame. Frames are bounded by 0x7E, 0x7D
// escapes the next byte (stored xor 0x20), and the first frame after idle is
// swallowed unchecked. A frame passes when it holds at least 14 bytes, byte 0
// is 0x80 and byte 13 equals the xor of bytes 0..12. A byte is taken every
// cycle while s_ready is high: the byte store and a running xor are updated
// on the beat itself, and the check and unpack of a closing delimiter are a
// short path from the store registers into the result register, so the
// result appears in the cycle after the delimiter beat. The result register
// can be emptied and reloaded in the same cycle, so input stalls only while
// that register is full and not being taken. No clearing pass follows reset.
module trainer_frame_decoder_core #(
    parameter int MAX_FRAME_BYTES = tfd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_rx_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [tfd_pkg::CHAN_W-1:0] m_chan0,
    output logic [tfd_pkg::CHAN_W-1:0] m_chan1,
    output logic [tfd_pkg::CHAN_W-1:0] m_chan2,
    output logic [tfd_pkg::CHAN_W-1:0] m_chan3,
    output logic [tfd_pkg::CHAN_W-1:0] m_chan4,
    output logic [tfd_pkg::CHAN_W-1:0] m_chan5,
    output logic [tfd_pkg::CHAN_W-1:0] m_chan6,
    output logic [tfd_pkg::CHAN_W-1:0] m_chan7
);
    import tfd_pkg::*;

    logic        s_accept;
    store_t      store;
    dfr_status_t status;
    chan_arr_t   chans;

    logic        m_valid_reg, m_valid_next;
    chan_arr_t   chan_reg;

    // input side is free whenever the result register is empty or draining
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // deframer: state, count, byte store, running xor and the frame check
    tfd_deframer #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_deframer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (s_accept),
        .byte_in     (s_rx_byte),
        .store       (store),
        .status      (status)
    );

    // channel unpack straight from the store
    tfd_unpack u_unpack (
        .store (store),
        .chans (chans)
    );

    // result register: loads on a passing delimiter beat, empties when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (status.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (status.emit) begin
            chan_reg <= chans;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_chan0 = chan_reg[0];
    assign m_chan1 = chan_reg[1];
    assign m_chan2 = chan_reg[2];
    assign m_chan3 = chan_reg[3];
    assign m_chan4 = chan_reg[4];
    assign m_chan5 = chan_reg[5];
    assign m_chan6 = chan_reg[6];
    assign m_chan7 = chan_reg[7];

    // a result only comes from an accepted beat seen in the in-frame state
    a_emit_on_beat : assert property (@(posedge aclk) disable iff (!aresetn)
        status.emit |-> (s_accept && status.in_frame))
        else $error("frame result raised without an accepted in-frame beat");

    // a passing frame always shows up on the result side next cycle
    a_emit_shows : assert property (@(posedge aclk) disable iff (!aresetn)
        status.emit |=> m_valid)
        else $error("passing frame did not reach the result register");

    // the result register never fills without an input beat behind it
    a_fill_cause : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result appeared without an accepted input beat");

endmodule
